[rtl/bmm_pkg.sv]
package bmm_pkg;

    localparam int MAX_DIM_DEF = 64;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 40;
    localparam int DIM_W       = 7;
    localparam int IDX_W       = 6;

    localparam logic [1:0] MODE_WR_A   = 2'd0;
    localparam logic [1:0] MODE_WR_B   = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;
    localparam logic [1:0] MODE_RD_C   = 2'd3;

    localparam logic [1:0] ST_READ = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_OOR  = 2'd2;

    typedef struct packed {
        logic [1:0]               mode;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         column;
        logic signed [ELEM_W-1:0] element;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [PROD_W-1:0] product_element;
    } out_item_t;

    // Classified command handed from front to back.
    typedef struct packed {
        logic [1:0]               op;
        logic                     oor;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         column;
        logic signed [ELEM_W-1:0] element;
        logic [DIM_W+1:0]         side;
    } cmd_t;

endpackage

[rtl/bmm_front.sv]
module bmm_front #(
    parameter int MAX_DIM = bmm_pkg::MAX_DIM_DEF,
    parameter int SIDE_W  = $clog2(MAX_DIM + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bmm_pkg::in_item_t  in_item,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SIDE_W-1:0]  side,
    output bmm_pkg::cmd_t      cmd,
    output logic               cmd_valid,
    input  logic               cmd_ready
);
    // Two-entry queue of classified commands.
    bmm_pkg::cmd_t q_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    bmm_pkg::cmd_t c;
    logic          push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        c         = '0;
        c.op      = in_item.mode;
        c.row     = in_item.row;
        c.column  = in_item.column;
        c.element = in_item.element;
        c.side    = (bmm_pkg::DIM_W+2)'(side);
        c.oor     = (in_item.mode != bmm_pkg::MODE_COMPUTE) &&
                    ((32'(in_item.row) >= 32'(side)) || (32'(in_item.column) >= 32'(side)));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !in_ready)
        else $error("full queue accepts");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |=> !pop || $past(push))
        else $error("pop from empty queue");
endmodule

[rtl/bmm_back.sv]
module bmm_back #(
    parameter int MAX_DIM = bmm_pkg::MAX_DIM_DEF,
    parameter int AW      = $clog2(MAX_DIM)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bmm_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    output bmm_pkg::out_item_t out_item,
    output logic               out_valid,
    input  logic               out_ready
);
    localparam int EW = bmm_pkg::ELEM_W;
    localparam int PW = bmm_pkg::PROD_W;
    localparam int DEPTH = 1 << (2*AW);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_RDC   = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;

    logic signed [EW-1:0] mem_a [DEPTH];
    logic signed [EW-1:0] mem_b [DEPTH];
    logic [PW-1:0]        mem_c [DEPTH];

    logic [2:0]       st_reg;
    logic [2*AW-1:0]  clr_reg;
    logic [AW:0]      i_reg, j_reg, k_reg, n_reg;
    logic             p1_reg, p2_reg, p2last_reg, p1last_reg;
    logic             first_p1_reg, first_p2_reg;
    logic signed [EW-1:0] a_rd_reg, b_rd_reg;
    logic signed [2*EW-1:0] mul_reg;
    logic signed [PW-1:0] acc_reg;
    logic [2*AW-1:0]  wadr1_reg, wadr2_reg;
    logic [PW-1:0]    c_rd_reg;
    logic             mac_pend_reg;
    logic             ovalid_reg;
    bmm_pkg::out_item_t oitem_reg;
    logic             idle_take;
    logic             k_last;
    logic signed [PW-1:0] acc_sum;
    logic [2*AW-1:0]  cmd_adr;

    assign out_valid = ovalid_reg;
    assign out_item  = oitem_reg;
    // Take a command only when the result slot is free or being emptied.
    assign idle_take = (st_reg == S_IDLE) && cmd_valid && (!ovalid_reg || out_ready);
    assign cmd_ready = idle_take;
    assign k_last    = (k_reg == n_reg - 1'b1);
    assign acc_sum   = (first_p2_reg ? '0 : acc_reg) + PW'(mul_reg);
    assign cmd_adr   = {AW'(cmd.row), AW'(cmd.column)};

    // Stores A and B: written by load commands, read by the MAC walk.
    always_ff @(posedge clk)
    begin
        if (idle_take && !cmd.oor && cmd.op == bmm_pkg::MODE_WR_A)
            mem_a[cmd_adr] <= cmd.element;
        if (idle_take && !cmd.oor && cmd.op == bmm_pkg::MODE_WR_B)
            mem_b[cmd_adr] <= cmd.element;
        a_rd_reg <= mem_a[{i_reg[AW-1:0], k_reg[AW-1:0]}];
        b_rd_reg <= mem_b[{k_reg[AW-1:0], j_reg[AW-1:0]}];
    end

    // Store C: one write port, shared by the clear sweep and the MAC results.
    always_ff @(posedge clk)
    begin
        if (st_reg == S_CLEAR)
            mem_c[clr_reg] <= '0;
        else if (p2_reg && p2last_reg)
            mem_c[wadr2_reg] <= acc_sum;
        c_rd_reg <= mem_c[cmd_adr];
    end

    // MAC pipeline: read, multiply, accumulate.
    always_ff @(posedge clk)
    begin
        mul_reg   <= a_rd_reg * b_rd_reg;
        acc_reg   <= acc_sum;
        wadr2_reg <= wadr1_reg;
        wadr1_reg <= {i_reg[AW-1:0], j_reg[AW-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_CLEAR;
            clr_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            n_reg        <= (AW+1)'(1);
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            p1last_reg   <= 1'b0;
            p2last_reg   <= 1'b0;
            mac_pend_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
            oitem_reg    <= '0;
        end
        else
        begin
            if (out_valid && out_ready) ovalid_reg <= 1'b0;
            p1_reg     <= (st_reg == S_MAC);
            p2_reg     <= p1_reg;
            // last-term flag travels with its product
            p1last_reg <= (st_reg == S_MAC) && k_last;
            p2last_reg <= p1last_reg;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (idle_take)
                    begin
                        if (cmd.oor)
                        begin
                            ovalid_reg <= 1'b1;
                            oitem_reg  <= '{bmm_pkg::ST_OOR, '0};
                        end
                        else if (cmd.op == bmm_pkg::MODE_COMPUTE)
                        begin
                            n_reg        <= (AW+1)'(cmd.side);
                            clr_reg      <= '0;
                            i_reg        <= '0;
                            j_reg        <= '0;
                            k_reg        <= '0;
                            mac_pend_reg <= 1'b1;
                            st_reg       <= S_CLEAR;
                        end
                        else if (cmd.op == bmm_pkg::MODE_RD_C)
                            st_reg <= S_RDC;
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (2*AW)'(DEPTH - 1))
                    begin
                        st_reg       <= mac_pend_reg ? S_MAC : S_IDLE;
                        mac_pend_reg <= 1'b0;
                    end
                end
                S_MAC:
                begin
                    k_reg <= k_last ? '0 : k_reg + 1'b1;
                    if (k_last)
                    begin
                        j_reg <= (j_reg == n_reg - 1'b1) ? '0 : j_reg + 1'b1;
                        if (j_reg == n_reg - 1'b1)
                        begin
                            i_reg <= i_reg + 1'b1;
                            if (i_reg == n_reg - 1'b1)
                                st_reg <= S_FILL;
                        end
                    end
                end
                S_FILL:
                begin
                    if (!p1_reg && !p2_reg && !ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        oitem_reg  <= '{bmm_pkg::ST_DONE, '0};
                        st_reg     <= S_IDLE;
                    end
                end
                S_RDC:
                begin
                    ovalid_reg <= 1'b1;
                    oitem_reg  <= '{bmm_pkg::ST_READ, c_rd_reg};
                    st_reg     <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // Accumulator: start fresh on the first term of each element.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_p1_reg <= 1'b0;
            first_p2_reg <= 1'b0;
        end
        else
        begin
            first_p1_reg <= (st_reg == S_MAC) && (k_reg == '0);
            first_p2_reg <= first_p1_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_RDC) |=> out_valid && out_item.status == bmm_pkg::ST_READ)
        else $error("read did not produce an item");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !cmd_ready)
        else $error("command taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_MAC) |-> (k_reg < n_reg) && (j_reg < n_reg))
        else $error("MAC index beyond side");
endmodule

[rtl/block_matrix_multiply_core.sv]
// Channel  | Signals                        | Item
// in       | in_valid, in_ready, in_item    | load A/B element, compute, read C
// out      | out_valid, out_ready, out_item | status and C element
// cfg      | cfg_we, cfg_data               | dimension register
// Loads finish and out-of-range items are answered in the idle state; a read of C passes through S_RDC.
// A compute clears store C one entry per cycle (4096 entries at the default
// size), then runs n*n*n multiply-accumulates, one per cycle, and waits for the
// pipeline to drain; the single MAC unit reading stores A and B sets this pace.
// After reset, store C is cleared in the same pass while no item is taken.
// The front queue (two items) keeps accepting while the back is busy, until it is full.
module block_matrix_multiply_core #(
    parameter int MAX_DIM = bmm_pkg::MAX_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  bmm_pkg::in_item_t            in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output bmm_pkg::out_item_t           out_item,
    input  logic                         cfg_we,
    input  logic [bmm_pkg::DIM_W-1:0]    cfg_data
);
    localparam int SIDE_W = $clog2(MAX_DIM + 1);

    logic [bmm_pkg::DIM_W-1:0] dim_reg;
    logic [SIDE_W-1:0]         side;
    bmm_pkg::cmd_t             cmd;
    logic                      cmd_valid, cmd_ready;

    // Hold the dimension register; the side taken from it is clamped to 1..MAX_DIM.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dim_reg <= bmm_pkg::DIM_W'(64);
        else if (cfg_we)
            dim_reg <= cfg_data;
    end

    always_comb
    begin
        if (dim_reg == '0)
            side = SIDE_W'(1);
        else if (32'(dim_reg) > MAX_DIM)
            side = SIDE_W'(MAX_DIM);
        else
            side = SIDE_W'(dim_reg);
    end

    bmm_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .in_valid(in_valid),
        .in_ready(in_ready), .side(side), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready)
    );

    bmm_back #(.MAX_DIM(MAX_DIM)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready), .out_item(out_item), .out_valid(out_valid),
        .out_ready(out_ready)
    );
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int SIDE_MAX  = bmm_pkg::MAX_DIM_DEF;
    localparam int DRAIN_CYC = 32;    // covers a load still in the front queue
    localparam int HOLD_CYC  = 3000;  // long receiver hold-off

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    bmm_pkg::in_item_t  in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    bmm_pkg::out_item_t out_item;
    logic               cfg_we = 1'b0;
    logic [bmm_pkg::DIM_W-1:0] cfg_data = '0;

    block_matrix_multiply_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the matrix stores and the dimension register.
    logic [bmm_pkg::ELEM_W-1:0] mat_a [SIDE_MAX*SIDE_MAX];
    logic [bmm_pkg::ELEM_W-1:0] mat_b [SIDE_MAX*SIDE_MAX];
    logic [bmm_pkg::PROD_W-1:0] mat_c [SIDE_MAX*SIDE_MAX];
    bit                         a_set [SIDE_MAX*SIDE_MAX];
    bit                         b_set [SIDE_MAX*SIDE_MAX];
    logic [bmm_pkg::DIM_W-1:0]  dim_reg;

    bmm_pkg::out_item_t pending_results[$];
    int        error_count;
    int        items_sent;
    int        results_seen;
    int        products_run;
    bit        quiet;        // no random idling on either side while set; a hold-off still applies
    int        hold_asked;   // bumped by a test to request a receiver hold-off
    int        hold_seen;
    int        hold_left;

    task automatic report(input string what);
        error_count++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    function automatic int side_now();
        if (dim_reg == 0)
            return 1;
        if (dim_reg > SIDE_MAX)
            return SIDE_MAX;
        return int'(dim_reg);
    endfunction

    // Plain matrix product over the top-left n x n part; C is cleared first.
    task automatic run_product(input int n);
        longint acc;
        for (int i = 0; i < SIDE_MAX*SIDE_MAX; i++)
            mat_c[i] = '0;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc += longint'($signed(mat_a[i*SIDE_MAX+k])) *
                           longint'($signed(mat_b[k*SIDE_MAX+j]));
                mat_c[i*SIDE_MAX+j] = acc[bmm_pkg::PROD_W-1:0];
            end
        products_run++;
    endtask

    // Update the shadow state for one accepted item and queue its result.
    task automatic predict_item(input bmm_pkg::in_item_t it);
        bmm_pkg::out_item_t r;
        int        n;
        int        idx;
        n   = side_now();
        idx = int'(it.row) * SIDE_MAX + int'(it.column);
        r   = '0;
        if (it.mode == bmm_pkg::MODE_COMPUTE)
        begin
            run_product(n);
            r.status = bmm_pkg::ST_DONE;
            pending_results.push_back(r);
        end
        else if (int'(it.row) >= n || int'(it.column) >= n)
        begin
            r.status = bmm_pkg::ST_OOR;
            pending_results.push_back(r);
        end
        else if (it.mode == bmm_pkg::MODE_WR_A)
        begin
            mat_a[idx] = it.element;
            a_set[idx] = 1'b1;
        end
        else if (it.mode == bmm_pkg::MODE_WR_B)
        begin
            mat_b[idx] = it.element;
            b_set[idx] = 1'b1;
        end
        else
        begin
            r.status          = bmm_pkg::ST_READ;
            r.product_element = mat_c[idx];
            pending_results.push_back(r);
        end
    endtask

    // Offer one item, called at a rising edge; valid stays up on return.
    task automatic send_item(input logic [1:0] mode, input int row, input int col,
                             input logic [bmm_pkg::ELEM_W-1:0] elem);
        bmm_pkg::in_item_t it;
        it.mode    = mode;
        it.row     = row[bmm_pkg::IDX_W-1:0];
        it.column  = col[bmm_pkg::IDX_W-1:0];
        it.element = elem;
        if (!quiet && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predict_item(it);
        items_sent++;
    endtask

    // Drop valid and let every result and queued load drain.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_dim(input logic [bmm_pkg::DIM_W-1:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        dim_reg  = v;
    endtask

    function automatic logic [bmm_pkg::ELEM_W-1:0] pick_elem();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return bmm_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    // Write every A and B entry of the n x n part that is still unset, so a
    // product never touches an unwritten entry.
    task automatic fill_unset(input int n);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                if (!a_set[i*SIDE_MAX+j])
                    send_item(bmm_pkg::MODE_WR_A, i, j, pick_elem());
                if (!b_set[i*SIDE_MAX+j])
                    send_item(bmm_pkg::MODE_WR_B, i, j, pick_elem());
            end
    endtask

    task automatic start_product();
        fill_unset(side_now());
        send_item(bmm_pkg::MODE_COMPUTE, $urandom_range(63), $urandom_range(63),
                  pick_elem());
    endtask

    // Receiver: check each result against the oldest expectation, then pick
    // the next ready value, honoring any requested hold-off.
    always @(posedge clk)
    begin
        bmm_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report($sformatf("unexpected result status=%0d data=%0d",
                                 out_item.status, out_item.product_element));
            else
            begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status)
                    report($sformatf("status got %0d want %0d",
                                     out_item.status, want.status));
                if (out_item.product_element !== want.product_element)
                    report($sformatf("product_element got %0d want %0d",
                                     out_item.product_element, want.product_element));
            end
        end
        if (hold_asked != hold_seen)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (quiet)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 31);
    end

    // Reads right after reset must see the cleared C store.
    task automatic test_reset_state();
        send_item(bmm_pkg::MODE_RD_C, 0, 0, '0);
        send_item(bmm_pkg::MODE_RD_C, 63, 63, '0);
        send_item(bmm_pkg::MODE_RD_C, 42, 21, '0);
    endtask

    // Field extremes, every mode, out-of-range indices and dimension clamps.
    task automatic test_directed();
        send_item(bmm_pkg::MODE_WR_A, 63, 0, 16'h8000);
        send_item(bmm_pkg::MODE_WR_B, 0, 63, 16'h7FFF);
        write_dim(7'd2);
        send_item(bmm_pkg::MODE_WR_A, 0, 0, 16'h8000);
        send_item(bmm_pkg::MODE_WR_A, 0, 1, 16'h8000);
        send_item(bmm_pkg::MODE_WR_A, 1, 0, 16'h7FFF);
        send_item(bmm_pkg::MODE_WR_A, 1, 1, 16'hFFFF);
        send_item(bmm_pkg::MODE_WR_B, 0, 0, 16'h8000);
        send_item(bmm_pkg::MODE_WR_B, 0, 1, 16'h7FFF);
        send_item(bmm_pkg::MODE_WR_B, 1, 0, 16'h8000);
        send_item(bmm_pkg::MODE_WR_B, 1, 1, 16'h0001);
        send_item(bmm_pkg::MODE_COMPUTE, 63, 63, 16'hFFFF);
        send_item(bmm_pkg::MODE_RD_C, 0, 0, '0);
        send_item(bmm_pkg::MODE_RD_C, 0, 1, '0);
        send_item(bmm_pkg::MODE_RD_C, 1, 0, '0);
        send_item(bmm_pkg::MODE_RD_C, 1, 1, '0);
        // out-of-range in each indexed mode
        send_item(bmm_pkg::MODE_WR_A, 2, 0, 16'h1234);
        send_item(bmm_pkg::MODE_WR_B, 0, 2, 16'h1234);
        send_item(bmm_pkg::MODE_RD_C, 63, 63, '0);
        // zero dimension acts as one
        write_dim(7'd0);
        send_item(bmm_pkg::MODE_COMPUTE, 0, 0, '0);
        send_item(bmm_pkg::MODE_RD_C, 0, 0, '0);
        send_item(bmm_pkg::MODE_RD_C, 0, 1, '0);
        // values above the maximum clamp to it
        write_dim(7'd127);
        send_item(bmm_pkg::MODE_RD_C, 63, 63, '0);
        send_item(bmm_pkg::MODE_WR_A, 63, 63, 16'hFFFF);
        write_dim(7'd64);
        send_item(bmm_pkg::MODE_RD_C, 1, 1, '0);
    endtask

    // Random phases, mostly small sides so each product stays short.
    task automatic test_random(input int budget);
        int start;
        int n;
        int pick;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                write_dim(7'd0);
            else if (pick < 12)
                write_dim(7'd64 + bmm_pkg::DIM_W'($urandom_range(63)));
            else if (pick < 15)
                write_dim(7'd16);
            else
                write_dim(bmm_pkg::DIM_W'($urandom_range(8, 1)));
            n = side_now();
            quiet = ($urandom_range(9) == 0);
            if (n <= 16)
                start_product();
            repeat ($urandom_range(50, 20))
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    send_item(pick[0] ? bmm_pkg::MODE_WR_B : bmm_pkg::MODE_WR_A,
                              $urandom_range(n - 1), $urandom_range(n - 1), pick_elem());
                else if (pick < 50)
                    send_item((pick % 4 == 2) ? bmm_pkg::MODE_RD_C : 2'(pick % 4),
                              $urandom_range(63), $urandom_range(63), pick_elem());
                else if (pick < 85)
                    send_item(bmm_pkg::MODE_RD_C, $urandom_range(n - 1),
                              $urandom_range(n - 1), pick_elem());
                else if (pick < 90 && n <= 16)
                    start_product();
                else
                    send_item(bmm_pkg::MODE_RD_C, $urandom_range(63), $urandom_range(63),
                              '0);
            end
            quiet = 1'b0;
        end
    endtask

    // Hold the receiver off while reads keep coming, so the block backs up.
    task automatic test_backpressure();
        write_dim(7'd4);
        start_product();
        wait_idle();
        quiet = 1'b1;
        hold_asked++;
        repeat (24)
            send_item(bmm_pkg::MODE_RD_C, $urandom_range(3), $urandom_range(3), '0);
        quiet = 1'b0;
    endtask

    initial
    begin
        error_count  = 0;
        items_sent   = 0;
        results_seen = 0;
        products_run = 0;
        quiet        = 1'b0;
        hold_asked   = 0;
        hold_seen    = 0;
        hold_left    = 0;
        dim_reg      = 7'd64;
        for (int i = 0; i < SIDE_MAX*SIDE_MAX; i++)
        begin
            mat_a[i] = '0;
            mat_b[i] = '0;
            mat_c[i] = '0;
            a_set[i] = 1'b0;
            b_set[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_backpressure();
        test_random(1600);

        wait_idle();
        $display("Covered %0d items, %0d results, %0d products over several sides.",
                 items_sent, results_seen, products_run);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(64'd200_000_000);
        $display("Timeout waiting for the block");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
